// ===== rtl/ilha_pkg.sv =====
// Shared constants for the implicit-list heap allocator.
package ilha_pkg;

  localparam int HEAP_WORDS_DEFAULT = 16384;
  localparam int WORD_BYTES         = 4;
  localparam int DWORD_BYTES        = 8;
  localparam int CHUNK_DEFAULT      = 1 << 12;
  localparam int MIN_BLOCK          = 16;
  localparam int HEAP_START         = 8;
  localparam int FIRST_BP           = 16;
  localparam int CHUNK_W            = 17;
  localparam int SIZE_W             = 16;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_NEXT  = 1'b1;

  localparam logic CFG_FIT_MODE = 1'b0;
  localparam logic CFG_CHUNK    = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

endpackage

// ===== rtl/implicit_list_heap_allocator_core.sv =====
// Implicit free-list heap allocator with boundary tags, first or next fit.
// One request at a time: busy stays high from acceptance until the result strobe;
// a zero-size allocate is answered from idle and never raises busy. Every other
// request walks block headers through one single-port heap RAM, reading each
// header in S_WRD and checking it in S_WCHK. After reset, the init state lays out
// the prologue, the initial chunk (when it fits in the heap) and the epilogue while
// busy is high. Results cannot be stalled: out_valid lasts one cycle.
module implicit_list_heap_allocator_core #(
  parameter int HEAP_WORDS = ilha_pkg::HEAP_WORDS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_action,
  input  logic [ilha_pkg::SIZE_W-1:0]  in_request_size,
  input  logic [ilha_pkg::SIZE_W-1:0]  in_block_address,
  output logic                         out_valid,
  output logic [ilha_pkg::SIZE_W-1:0]  out_payload_address,
  output logic [1:0]                   out_status,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [ilha_pkg::CHUNK_W-1:0] cfg_data
);

  localparam int IW  = $clog2(HEAP_WORDS);
  localparam int AW  = (IW + 3 > 19) ? IW + 3 : 19;
  localparam int HEAP_BYTES = HEAP_WORDS * ilha_pkg::WORD_BYTES;
  localparam bit INIT_FITS =
    (ilha_pkg::FIRST_BP + ilha_pkg::CHUNK_DEFAULT) <= HEAP_BYTES;
  localparam logic [AW-1:0] BRK_INIT = INIT_FITS ?
    AW'(ilha_pkg::FIRST_BP + ilha_pkg::CHUNK_DEFAULT) : AW'(ilha_pkg::FIRST_BP);
  localparam logic [AW-1:0] HEAP_LIM = AW'(HEAP_BYTES);
  localparam logic [AW-1:0] A_START  = AW'(ilha_pkg::HEAP_START);
  localparam logic [AW-1:0] A_FIRST  = AW'(ilha_pkg::FIRST_BP);
  localparam logic [AW-1:0] A_MIN    = AW'(ilha_pkg::MIN_BLOCK);
  localparam logic [AW-1:0] A_WORD   = AW'(ilha_pkg::WORD_BYTES);
  localparam logic [AW-1:0] A_DWORD  = AW'(ilha_pkg::DWORD_BYTES);
  localparam logic [AW-1:0] SZ_MASK  = ~AW'(7);
  localparam logic [31:0]   TAG_PRO  = 32'(ilha_pkg::DWORD_BYTES + 1);
  localparam logic [31:0]   TAG_CHK  = 32'(ilha_pkg::CHUNK_DEFAULT);
  localparam logic [31:0]   TAG_EPI  = 32'd1;
  localparam logic [IW-1:0] W_PROH   = IW'(1);
  localparam logic [IW-1:0] W_PROF   = IW'(2);
  localparam logic [IW-1:0] W_CHKH   = IW'(3);
  localparam logic [IW-1:0] W_CHKF   =
    IW'((ilha_pkg::FIRST_BP + ilha_pkg::CHUNK_DEFAULT - 8) / 4);
  localparam logic [IW-1:0] W_EPI    =
    IW'((ilha_pkg::FIRST_BP + ilha_pkg::CHUNK_DEFAULT - 4) / 4);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WRD, S_WCHK, S_GEPI, S_MRDN, S_MRDP, S_MCALC,
    S_MWH, S_MWF, S_P0, S_P1, S_P2, S_P3
  } state_t;

  state_t          state_r, state_nxt;
  logic [2:0]      init_r, init_nxt;
  logic            kind_r, kind_nxt;
  logic            pass_r, pass_nxt;
  logic            from_free_r, from_free_nxt;
  logic            split_r, split_nxt;
  logic [AW-1:0]   bp_r, bp_nxt;
  logic [AW-1:0]   sz_r, sz_nxt;
  logic [AW-1:0]   asize_r, asize_nxt;
  logic [AW-1:0]   ext_r, ext_nxt;
  logic [ilha_pkg::SIZE_W-1:0] addr_r, addr_nxt;
  logic            fit_r, fit_nxt;
  logic [ilha_pkg::CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [AW-1:0]   rover_r, rover_nxt;
  logic [AW-1:0]   brk_r, brk_nxt;
  logic            ov_r, ov_nxt;
  logic [ilha_pkg::SIZE_W-1:0] opay_r, opay_nxt;
  logic [1:0]      ost_r, ost_nxt;

  logic            mem_we;
  logic [IW-1:0]   mem_addr;
  logic [31:0]     mem_wdata, mem_rdata;

  logic [AW-1:0]   tag_sz, a_asize, a_ch, a_ext, bp_ext, a_tmp, rem;
  logic            tag_al;

  ilha_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_heap (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;   init_nxt = init_r;   kind_nxt = kind_r;
    pass_nxt = pass_r;     from_free_nxt = from_free_r;  split_nxt = split_r;
    bp_nxt = bp_r;         sz_nxt = sz_r;       asize_nxt = asize_r;
    ext_nxt = ext_r;       addr_nxt = addr_r;   fit_nxt = fit_r;
    chunk_nxt = chunk_r;   rover_nxt = rover_r; brk_nxt = brk_r;
    ov_nxt = 1'b0;         opay_nxt = opay_r;   ost_nxt = ost_r;
    mem_we = 1'b0;         mem_addr = '0;       mem_wdata = '0;
    tag_sz = mem_rdata[AW-1:0] & SZ_MASK;
    tag_al = mem_rdata[0];
    a_asize = (in_request_size <= ilha_pkg::SIZE_W'(ilha_pkg::DWORD_BYTES)) ? A_MIN :
              ((AW'(in_request_size) + AW'(15)) & SZ_MASK);
    a_ch  = (AW'(chunk_r) + AW'(7)) & SZ_MASK;
    a_ext = (a_asize > a_ch) ? a_asize : a_ch;
    bp_ext = bp_r + ext_r;
    a_tmp = '0;
    rem   = sz_r - asize_r;

    if (cfg_we) begin
      if (cfg_index == ilha_pkg::CFG_FIT_MODE) begin
        fit_nxt = cfg_data[0];
      end else begin
        chunk_nxt = cfg_data;
      end
    end

    case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
        init_nxt = init_r + 3'd1;
        case (init_r)
          3'd0: begin mem_addr = W_PROH; mem_wdata = TAG_PRO; end
          3'd1: begin mem_addr = W_PROF; mem_wdata = TAG_PRO; end
          3'd2: begin
            mem_addr = W_CHKH;
            mem_wdata = INIT_FITS ? TAG_CHK : TAG_EPI;
            if (!INIT_FITS) state_nxt = S_IDLE;
          end
          3'd3: begin mem_addr = W_CHKF; mem_wdata = TAG_CHK; end
          default: begin
            mem_addr = W_EPI; mem_wdata = TAG_EPI; state_nxt = S_IDLE;
          end
        endcase
      end
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_action;
          addr_nxt = in_block_address;
          asize_nxt = a_asize;
          ext_nxt = a_ext;
          pass_nxt = 1'b0;
          if (in_action == ilha_pkg::ACT_FREE) begin
            bp_nxt = A_FIRST;
            state_nxt = S_WRD;
          end else if (in_request_size == '0) begin
            ov_nxt = 1'b1; opay_nxt = '0; ost_nxt = ilha_pkg::ST_IGNORED;
          end else begin
            bp_nxt = (fit_r == ilha_pkg::FIT_NEXT) ? rover_r : A_START;
            state_nxt = S_WRD;
          end
        end
      end
      S_WRD: begin
        if (kind_r == ilha_pkg::ACT_ALLOC && pass_r && bp_r >= rover_r) begin
          rover_nxt = bp_r;
          ext_nxt = ext_r;
          if (brk_r + ext_r > HEAP_LIM) begin
            ov_nxt = 1'b1; opay_nxt = '0; ost_nxt = ilha_pkg::ST_FULL;
            state_nxt = S_IDLE;
          end else begin
            bp_nxt = brk_r; sz_nxt = ext_r; brk_nxt = brk_r + ext_r;
            state_nxt = S_GEPI;
          end
        end else begin
          a_tmp = bp_r - A_WORD;
          mem_addr = a_tmp[IW+1:2];
          state_nxt = S_WCHK;
        end
      end
      S_WCHK: begin
        if (kind_r == ilha_pkg::ACT_FREE) begin
          if (tag_sz == '0 || bp_r > AW'(addr_r)) begin
            ov_nxt = 1'b1; opay_nxt = '0; ost_nxt = ilha_pkg::ST_IGNORED;
            state_nxt = S_IDLE;
          end else if (bp_r == AW'(addr_r)) begin
            if (tag_al) begin
              sz_nxt = tag_sz; from_free_nxt = 1'b1; state_nxt = S_MRDN;
            end else begin
              ov_nxt = 1'b1; opay_nxt = '0; ost_nxt = ilha_pkg::ST_IGNORED;
              state_nxt = S_IDLE;
            end
          end else begin
            bp_nxt = bp_r + tag_sz; state_nxt = S_WRD;
          end
        end else begin
          if (tag_sz == '0) begin
            if (fit_r == ilha_pkg::FIT_NEXT && !pass_r) begin
              pass_nxt = 1'b1; bp_nxt = A_START; state_nxt = S_WRD;
            end else begin
              if (fit_r == ilha_pkg::FIT_NEXT) rover_nxt = bp_r;
              if (brk_r + ext_r > HEAP_LIM) begin
                ov_nxt = 1'b1; opay_nxt = '0; ost_nxt = ilha_pkg::ST_FULL;
                state_nxt = S_IDLE;
              end else begin
                bp_nxt = brk_r; sz_nxt = ext_r; brk_nxt = brk_r + ext_r;
                state_nxt = S_GEPI;
              end
            end
          end else if (!tag_al && tag_sz >= asize_r) begin
            sz_nxt = tag_sz; state_nxt = S_P0;
          end else begin
            bp_nxt = bp_r + tag_sz; state_nxt = S_WRD;
          end
        end
      end
      S_GEPI: begin
        a_tmp = bp_ext - A_WORD;
        mem_we = 1'b1; mem_addr = a_tmp[IW+1:2]; mem_wdata = TAG_EPI;
        from_free_nxt = 1'b0;
        state_nxt = S_MRDP;
      end
      S_MRDN: begin
        a_tmp = bp_r + sz_r - A_WORD;
        mem_addr = a_tmp[IW+1:2];
        state_nxt = S_MRDP;
      end
      S_MRDP: begin
        if (from_free_r && !tag_al) sz_nxt = sz_r + tag_sz;
        a_tmp = bp_r - A_DWORD;
        mem_addr = a_tmp[IW+1:2];
        state_nxt = S_MCALC;
      end
      S_MCALC: begin
        if (!tag_al) begin
          bp_nxt = bp_r - tag_sz; sz_nxt = sz_r + tag_sz;
        end
        state_nxt = S_MWH;
      end
      S_MWH: begin
        a_tmp = bp_r - A_WORD;
        mem_we = 1'b1; mem_addr = a_tmp[IW+1:2];
        mem_wdata = 32'(sz_r);
        if (rover_r > bp_r && rover_r < bp_r + sz_r) rover_nxt = bp_r;
        state_nxt = S_MWF;
      end
      S_MWF: begin
        a_tmp = bp_r + sz_r - A_DWORD;
        mem_we = 1'b1; mem_addr = a_tmp[IW+1:2];
        mem_wdata = 32'(sz_r);
        if (from_free_r) begin
          ov_nxt = 1'b1; opay_nxt = '0; ost_nxt = ilha_pkg::ST_DONE;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_P0;
        end
      end
      S_P0: begin
        a_tmp = bp_r - A_WORD;
        mem_we = 1'b1; mem_addr = a_tmp[IW+1:2];
        split_nxt = rem >= A_MIN;
        mem_wdata = (rem >= A_MIN) ? (32'(asize_r) | TAG_EPI) : (32'(sz_r) | TAG_EPI);
        state_nxt = (rem >= A_MIN) ? S_P1 : S_P3;
      end
      S_P1: begin
        a_tmp = bp_r + asize_r - A_DWORD;
        mem_we = 1'b1; mem_addr = a_tmp[IW+1:2];
        mem_wdata = 32'(asize_r) | TAG_EPI;
        state_nxt = S_P2;
      end
      S_P2: begin
        a_tmp = bp_r + asize_r - A_WORD;
        mem_we = 1'b1; mem_addr = a_tmp[IW+1:2];
        mem_wdata = 32'(rem);
        state_nxt = S_P3;
      end
      S_P3: begin
        a_tmp = bp_r + sz_r - A_DWORD;
        mem_we = 1'b1; mem_addr = a_tmp[IW+1:2];
        mem_wdata = split_r ? 32'(rem) : (32'(sz_r) | TAG_EPI);
        rover_nxt = split_r ? bp_r + asize_r : bp_r + sz_r;
        ov_nxt = 1'b1; opay_nxt = bp_r[ilha_pkg::SIZE_W-1:0];
        ost_nxt = ilha_pkg::ST_DONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r  <= '0;
      fit_r   <= ilha_pkg::FIT_NEXT;
      chunk_r <= ilha_pkg::CHUNK_W'(ilha_pkg::CHUNK_DEFAULT);
      rover_r <= A_START;
      brk_r   <= BRK_INIT;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      fit_r   <= fit_nxt;
      chunk_r <= chunk_nxt;
      rover_r <= rover_nxt;
      brk_r   <= brk_nxt;
      ov_r    <= ov_nxt;
    end
    kind_r      <= kind_nxt;
    pass_r      <= pass_nxt;
    from_free_r <= from_free_nxt;
    split_r     <= split_nxt;
    bp_r        <= bp_nxt;
    sz_r        <= sz_nxt;
    asize_r     <= asize_nxt;
    ext_r       <= ext_nxt;
    addr_r      <= addr_nxt;
    opay_r      <= opay_nxt;
    ost_r       <= ost_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = ov_r;
  assign out_payload_address = opay_r;
  assign out_status          = ost_r;

  a_rover_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    rover_r[2:0] == 3'd0) else $error("rover off alignment");
  a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    brk_r <= HEAP_LIM) else $error("heap break past end");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ilha_pkg::ST_DONE |-> out_payload_address == '0)
    else $error("failed request carries an address");
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start)) else $error("spurious result");

endmodule

// ===== rtl/ilha_ram.sv =====
// Generic single-port RAM with registered read.
module ilha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== bench/tb_implicit_list_heap_allocator_core.sv =====
// Self-checking testbench for the implicit-list heap allocator core.
module tb_implicit_list_heap_allocator_core;

  localparam int HW = ilha_pkg::HEAP_WORDS_DEFAULT;
  localparam int SPAN = HW * 4;
  localparam int SW = ilha_pkg::SIZE_W;
  localparam int CW = ilha_pkg::CHUNK_W;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic          act;
    logic [SW-1:0] size;
    logic [SW-1:0] addr;
  } request_t;

  typedef struct packed {
    logic [SW-1:0] paddr;
    logic [1:0]    status;
  } outcome_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  logic           in_action = ilha_pkg::ACT_ALLOC;
  logic [SW-1:0]  in_request_size = '0;
  logic [SW-1:0]  in_block_address = '0;
  logic           out_valid;
  logic [SW-1:0]  out_payload_address;
  logic [1:0]     out_status;
  logic           cfg_we = 1'b0;
  logic           cfg_index = ilha_pkg::CFG_FIT_MODE;
  logic [CW-1:0]  cfg_data = '0;

  request_t    pending_reqs[$];
  outcome_t    expected_results[$];
  int unsigned live_blocks[$];
  int          idle_pct = 0;
  int          mismatches = 0;
  longint      cycles = 0;

  // allocator shadow state
  int unsigned heap_img[HW];
  int unsigned rover;
  int unsigned brk;
  logic        fit_sel;
  int unsigned chunk_sz;

  implicit_list_heap_allocator_core u_top (.*);

  always #5 clk = ~clk;

  function automatic int unsigned hw_rd(int unsigned off);
    return (off / 4 < HW) ? heap_img[off / 4] : 0;
  endfunction

  function automatic void hw_wr(int unsigned off, int unsigned v);
    if (off / 4 < HW) heap_img[off / 4] = v;
  endfunction

  function automatic int unsigned size_of(int unsigned bp);
    return hw_rd(bp - 4) & ~32'h7;
  endfunction

  function automatic void set_tags(int unsigned bp, int unsigned sz, int unsigned a);
    hw_wr(bp - 4, sz | a);
    hw_wr(bp + sz - 8, sz | a);
  endfunction

  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned sz, prev_tag, nxt;
    sz = size_of(bp);
    prev_tag = hw_rd(bp - 8);
    nxt = bp + sz;
    if ((hw_rd(nxt - 4) & 1) == 0) sz += size_of(nxt);
    if ((prev_tag & 1) == 0) begin
      bp -= prev_tag & ~32'h7;
      sz += prev_tag & ~32'h7;
    end
    set_tags(bp, sz, 0);
    if (rover > bp && rover < bp + sz) rover = bp;
    return bp;
  endfunction

  function automatic int unsigned grow_heap(int unsigned ext);
    int unsigned bp;
    bp = brk;
    brk += ext;
    set_tags(bp, ext, 0);
    hw_wr(bp + ext - 4, 1);
    return coalesce(bp);
  endfunction

  function automatic int unsigned walk(int unsigned from, int unsigned lim,
                                       int unsigned asize, output int unsigned stop);
    int unsigned bp, h, s;
    bp = from;
    for (int n = 0; n < HW; n++) begin
      if (lim != 0 && bp >= lim) break;
      h = hw_rd(bp - 4);
      s = h & ~32'h7;
      if (s == 0) break;
      if ((h & 1) == 0 && s >= asize) begin
        stop = bp;
        return bp;
      end
      bp += s;
    end
    stop = bp;
    return 0;
  endfunction

  function automatic int unsigned locate_block(int unsigned asize);
    int unsigned stop, bp, old;
    if (fit_sel == ilha_pkg::FIT_FIRST) return walk(ilha_pkg::HEAP_START, 0, asize, stop);
    old = rover;
    bp = walk(old, 0, asize, stop);
    if (bp == 0) bp = walk(ilha_pkg::HEAP_START, old, asize, stop);
    rover = stop;
    return bp;
  endfunction

  function automatic void place(int unsigned bp, int unsigned asize);
    int unsigned fs;
    fs = size_of(bp);
    if (fs - asize >= ilha_pkg::MIN_BLOCK) begin
      set_tags(bp, asize, 1);
      set_tags(bp + asize, fs - asize, 0);
      rover = bp + asize;
    end else begin
      set_tags(bp, fs, 1);
      rover = bp + fs;
    end
  endfunction

  function automatic bit owned(int unsigned addr);
    int unsigned bp, h;
    bp = ilha_pkg::FIRST_BP;
    for (int n = 0; n < HW; n++) begin
      h = hw_rd(bp - 4);
      if ((h & ~32'h7) == 0 || bp > addr) return 0;
      if (bp == addr) return (h & 1) != 0;
      bp += h & ~32'h7;
    end
    return 0;
  endfunction

  function automatic void heap_init();
    int unsigned dummy;
    foreach (heap_img[i]) heap_img[i] = 0;
    fit_sel = ilha_pkg::FIT_NEXT;
    chunk_sz = ilha_pkg::CHUNK_DEFAULT;
    hw_wr(4, 9);
    hw_wr(8, 9);
    hw_wr(12, 1);
    brk = 16;
    rover = ilha_pkg::HEAP_START;
    if (brk + ilha_pkg::CHUNK_DEFAULT <= SPAN) dummy = grow_heap(ilha_pkg::CHUNK_DEFAULT);
  endfunction

  function automatic outcome_t serve(request_t r);
    outcome_t o;
    int unsigned asize, bp, ch, ext;
    o = '0;
    if (r.act == ilha_pkg::ACT_FREE) begin
      if (owned(r.addr)) begin
        set_tags(r.addr, size_of(r.addr), 0);
        bp = coalesce(r.addr);
      end else o.status = ilha_pkg::ST_IGNORED;
    end else if (r.size == 0) begin
      o.status = ilha_pkg::ST_IGNORED;
    end else begin
      asize = (r.size <= 8) ? ilha_pkg::MIN_BLOCK : ((r.size + 15) & ~32'h7);
      bp = locate_block(asize);
      if (bp == 0) begin
        ch = (chunk_sz + 7) & ~32'h7;
        ext = (asize > ch) ? asize : ch;
        if (brk + ext > SPAN) o.status = ilha_pkg::ST_FULL;
        else bp = grow_heap(ext);
      end
      if (bp != 0) begin
        place(bp, asize);
        o.paddr = bp[SW-1:0];
      end
    end
    return o;
  endfunction

  task automatic issue(logic act, int unsigned size, int unsigned addr);
    request_t r;
    outcome_t o;
    r.act = act;
    r.size = size[SW-1:0];
    r.addr = addr[SW-1:0];
    o = serve(r);
    if (act == ilha_pkg::ACT_ALLOC && o.status == ilha_pkg::ST_DONE)
      live_blocks.push_back(o.paddr);
    if (act == ilha_pkg::ACT_FREE && o.status == ilha_pkg::ST_DONE)
      foreach (live_blocks[i])
        if (live_blocks[i] == r.addr) begin
          live_blocks.delete(i);
          break;
        end
    pending_reqs.push_back(r);
    expected_results.push_back(o);
  endtask

  task automatic free_nth(int k);
    issue(ilha_pkg::ACT_FREE, $urandom, live_blocks[k]);
  endtask

  function automatic int unsigned pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 128);
    if (r < 90) return $urandom_range(129, 2048);
    if (r < 97) return $urandom_range(2049, 8000);
    return $urandom_range(0, 65535);
  endfunction

  task automatic random_traffic(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (live_blocks.size() > 0 && (r < 45 || live_blocks.size() > 150))
        free_nth($urandom_range(0, live_blocks.size() - 1));
      else if (r < 92)
        issue(ilha_pkg::ACT_ALLOC, pick_size(), $urandom);
      else if (r < 96 && live_blocks.size() > 0)
        issue(ilha_pkg::ACT_FREE, $urandom,
              live_blocks[$urandom_range(0, live_blocks.size() - 1)]
              + 8 * $urandom_range(1, 3));
      else
        issue(ilha_pkg::ACT_FREE, $urandom, $urandom_range(0, 65535));
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || start)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CW-1:0];
    if (idx == ilha_pkg::CFG_FIT_MODE) fit_sel = val[0];
    else chunk_sz = val[CW-1:0];
  endtask

  task automatic reconfigure(logic fit, int unsigned chunk, int idle);
    reg_write(ilha_pkg::CFG_FIT_MODE, fit);
    reg_write(ilha_pkg::CFG_CHUNK, chunk);
    @(posedge clk);
    cfg_we <= 1'b0;
    idle_pct = idle;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        in_action <= pending_reqs[0].act;
        in_request_size <= pending_reqs[0].size;
        in_block_address <= pending_reqs[0].addr;
        void'(pending_reqs.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t exp_o;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result addr=%0d status=%0d",
                                       out_payload_address, out_status);
      end else begin
        exp_o = expected_results.pop_front();
        if (exp_o.paddr !== out_payload_address || exp_o.status !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                     exp_o.paddr, exp_o.status, out_payload_address, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned a;
    heap_init();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: tiny and odd sizes, bad frees, exhaustion, merging both sides
    issue(ilha_pkg::ACT_ALLOC, 0, 16'hFFFF);
    issue(ilha_pkg::ACT_ALLOC, 1, 0);
    issue(ilha_pkg::ACT_ALLOC, 8, 0);
    issue(ilha_pkg::ACT_ALLOC, 9, 0);
    issue(ilha_pkg::ACT_ALLOC, 16, 0);
    issue(ilha_pkg::ACT_FREE, 16'hFFFF, 0);
    issue(ilha_pkg::ACT_FREE, 0, 16'hFFFF);
    issue(ilha_pkg::ACT_FREE, 0, ilha_pkg::FIRST_BP + 8);
    a = live_blocks[0];
    free_nth(0);
    issue(ilha_pkg::ACT_FREE, 0, a);
    issue(ilha_pkg::ACT_ALLOC, 16'hFFFF, 0);
    issue(ilha_pkg::ACT_ALLOC, 4000, 0);
    issue(ilha_pkg::ACT_ALLOC, 5000, 0);
    issue(ilha_pkg::ACT_ALLOC, 100, 0);
    issue(ilha_pkg::ACT_ALLOC, 200, 0);
    issue(ilha_pkg::ACT_ALLOC, 300, 0);
    free_nth(live_blocks.size() - 3);
    free_nth(live_blocks.size() - 1);
    free_nth(live_blocks.size() - 1);
    issue(ilha_pkg::ACT_ALLOC, 40000, 0);
    issue(ilha_pkg::ACT_ALLOC, 16'h8000, 0);
    random_traffic(230);
    drain();

    reconfigure(ilha_pkg::FIT_FIRST, 16, 59);
    random_traffic(250);
    drain();
    reconfigure(ilha_pkg::FIT_NEXT, 65536, 26);
    random_traffic(250);
    drain();
    reconfigure(ilha_pkg::FIT_FIRST, 4099, 0);
    random_traffic(250);
    drain();
    reconfigure(ilha_pkg::FIT_NEXT, 24, 59);
    random_traffic(250);
    drain();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
